FILE: design/gesc_pkg.sv
package gesc_pkg;

    localparam int GRID_SIZE     = 16;
    localparam int MAX_CELL_SIZE = 64;
    localparam int PIXEL_BITS    = 32;

    localparam int GRID_W  = $clog2(GRID_SIZE);
    localparam int CIDX_W  = $clog2(MAX_CELL_SIZE);
    localparam int EFF_W   = $clog2(MAX_CELL_SIZE + 1);
    localparam int PROD_W  = GRID_W + EFF_W;

    localparam int PIX_W   = 32;
    localparam int SIZE_W  = 7;
    localparam int CODE_W  = 8;
    localparam int COORD_W = 10;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 32;

    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [DATA_W-1:0] BG_RESET = '0;
    localparam logic [SIZE_W-1:0] CW_RESET = SIZE_W'(16);
    localparam logic [SIZE_W-1:0] CH_RESET = SIZE_W'(16);

    typedef enum logic [IDX_W-1:0] {
        REG_BACKGROUND  = 2'd0,
        REG_CELL_WIDTH  = 2'd1,
        REG_CELL_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [EFF_W-1:0] w;
        logic [EFF_W-1:0] h;
    } t_sizes;

    // one finished band of cell rows
    typedef struct packed {
        logic [GRID_SIZE-1:0]             seen;
        logic [GRID_SIZE-1:0][CIDX_W-1:0] left;
        logic [GRID_SIZE-1:0][CIDX_W-1:0] right;
        logic [GRID_W-1:0]                row;
    } t_band;

    typedef struct packed {
        logic [CODE_W-1:0]  char_code;
        logic [COORD_W-1:0] glyph_x;
        logic [COORD_W-1:0] glyph_y;
        logic [SIZE_W-1:0]  glyph_width;
        logic [SIZE_W-1:0]  glyph_height;
        logic               last;
    } t_glyph;

    // zero acts as one, oversize clamps
    function automatic logic [EFF_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [EFF_W-1:0] r;
        if (v == '0) begin
            r = EFF_W'(1);
        end else if (int'(v) > MAX_CELL_SIZE) begin
            r = EFF_W'(MAX_CELL_SIZE);
        end else begin
            r = EFF_W'(v);
        end
        return r;
    endfunction

endpackage

FILE: design/gesc_if.sv
interface gesc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [gesc_pkg::IDX_W-1:0]  index;
    logic [gesc_pkg::DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface gesc_pix_if;
    logic                       valid;
    logic                       ready;
    logic [gesc_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface gesc_glyph_if;
    logic                         valid;
    logic                         ready;
    logic [gesc_pkg::CODE_W-1:0]  char_code;
    logic [gesc_pkg::COORD_W-1:0] glyph_x;
    logic [gesc_pkg::COORD_W-1:0] glyph_y;
    logic [gesc_pkg::SIZE_W-1:0]  glyph_width;
    logic [gesc_pkg::SIZE_W-1:0]  glyph_height;
    logic                         last;

    modport source (output valid, output char_code, output glyph_x, output glyph_y,
                     output glyph_width, output glyph_height, output last, input ready);
    modport sink   (input valid, input char_code, input glyph_x, input glyph_y,
                     input glyph_width, input glyph_height, input last, output ready);
endinterface

FILE: design/gesc_front.sv
module gesc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gesc_pkg::t_sizes                i_size,
    input  logic [gesc_pkg::PIXEL_BITS-1:0] i_bg,
    gesc_pix_if.sink                        i_pix,
    output logic                            o_push,
    output gesc_pkg::t_band                 o_band,
    input  logic                            i_full
);
    import gesc_pkg::*;

    logic [CIDX_W-1:0] r_col, n_col;
    logic [GRID_W-1:0] r_cc, n_cc;
    logic [CIDX_W-1:0] r_row, n_row;
    logic [GRID_W-1:0] r_crow, n_crow;
    logic [GRID_SIZE-1:0]             r_seen, n_seen;
    logic [GRID_SIZE-1:0][CIDX_W-1:0] r_left, n_left;
    logic [GRID_SIZE-1:0][CIDX_W-1:0] r_right, n_right;

    logic [EFF_W-1:0] col_inc, row_inc;
    logic col_wrap, cc_wrap, row_wrap, crow_wrap, band_end;
    logic accept, hit;

    assign col_inc   = EFF_W'(r_col) + EFF_W'(1);
    assign row_inc   = EFF_W'(r_row) + EFF_W'(1);
    assign col_wrap  = col_inc >= i_size.w;
    assign row_wrap  = row_inc >= i_size.h;
    assign cc_wrap   = r_cc == GRID_W'(GRID_SIZE - 1);
    assign crow_wrap = r_crow == GRID_W'(GRID_SIZE - 1);
    assign band_end  = col_wrap && cc_wrap && row_wrap;

    assign i_pix.ready = !(band_end && i_full);
    assign accept      = i_pix.valid && i_pix.ready;
    assign hit         = (i_pix.pixel[PIXEL_BITS-1:0] != i_bg)
                         && (EFF_W'(r_col) < i_size.w);

    always_comb begin
        n_seen  = r_seen;
        n_left  = r_left;
        n_right = r_right;
        if (accept && hit) begin
            if (!r_seen[r_cc]) begin
                n_seen[r_cc]  = 1'b1;
                n_left[r_cc]  = r_col;
                n_right[r_cc] = r_col;
            end else begin
                if (r_col < r_left[r_cc]) begin
                    n_left[r_cc] = r_col;
                end
                if (r_col > r_right[r_cc]) begin
                    n_right[r_cc] = r_col;
                end
            end
        end
    end

    always_comb begin
        n_col  = r_col;
        n_cc   = r_cc;
        n_row  = r_row;
        n_crow = r_crow;
        if (accept) begin
            n_col = col_wrap ? '0 : CIDX_W'(col_inc);
            if (col_wrap) begin
                n_cc = cc_wrap ? '0 : r_cc + GRID_W'(1);
                if (cc_wrap) begin
                    n_row = row_wrap ? '0 : CIDX_W'(row_inc);
                    if (row_wrap) begin
                        n_crow = crow_wrap ? '0 : r_crow + GRID_W'(1);
                    end
                end
            end
        end
    end

    assign o_push      = accept && band_end;
    assign o_band.seen  = n_seen;
    assign o_band.left  = n_left;
    assign o_band.right = n_right;
    assign o_band.row   = r_crow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_cc   <= '0;
            r_row  <= '0;
            r_crow <= '0;
            r_seen <= '0;
        end else begin
            r_col  <= n_col;
            r_cc   <= n_cc;
            r_row  <= n_row;
            r_crow <= n_crow;
            if (accept) begin
                r_seen <= band_end ? '0 : n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
    end

endmodule

FILE: design/gesc_band_fifo.sv
module gesc_band_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gesc_pkg::t_band i_data,
    output logic            o_full,
    output logic            o_valid,
    output gesc_pkg::t_band o_data,
    input  logic            i_pop
);
    import gesc_pkg::*;

    t_band             r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wr, r_rd;
    logic [FCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = r_cnt == FCNT_W'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + FPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + FPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + FCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - FCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: design/gesc_back.sv
module gesc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gesc_pkg::t_sizes i_size,
    input  logic             i_valid,
    input  gesc_pkg::t_band  i_band,
    output logic             o_pop,
    gesc_glyph_if.source     o_glyph
);
    import gesc_pkg::*;

    logic [GRID_W-1:0] r_c;
    logic              r_ov;
    t_glyph            r_out;
    t_glyph            rec;

    logic              load, is_last;
    logic [CIDX_W-1:0] left, right;
    logic [PROD_W-1:0] cell_x, fg_x, top_y;
    logic [EFF_W-1:0]  fg_w;

    assign load    = i_valid && (!r_ov || o_glyph.ready);
    assign is_last = r_c == GRID_W'(GRID_SIZE - 1);
    assign left    = i_band.left[r_c];
    assign right   = i_band.right[r_c];
    assign cell_x  = {{EFF_W{1'b0}}, r_c} * {{GRID_W{1'b0}}, i_size.w};
    assign fg_x    = cell_x + PROD_W'(left);
    assign fg_w    = EFF_W'(right) - EFF_W'(left) + EFF_W'(1);
    assign top_y   = {{EFF_W{1'b0}}, i_band.row} * {{GRID_W{1'b0}}, i_size.h};

    always_comb begin
        rec.char_code    = CODE_W'(int'(i_band.row) * GRID_SIZE + int'(r_c));
        rec.glyph_x      = i_band.seen[r_c] ? COORD_W'(fg_x) : COORD_W'(cell_x);
        rec.glyph_y      = COORD_W'(top_y);
        rec.glyph_width  = i_band.seen[r_c] ? SIZE_W'(fg_w) : SIZE_W'(i_size.w);
        rec.glyph_height = SIZE_W'(i_size.h);
        rec.last         = is_last;
    end

    assign o_pop = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c  <= '0;
            r_ov <= 1'b0;
        end else begin
            if (load) begin
                r_c  <= is_last ? '0 : r_c + GRID_W'(1);
                r_ov <= 1'b1;
            end else if (o_glyph.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= rec;
        end
    end

    assign o_glyph.valid        = r_ov;
    assign o_glyph.char_code    = r_out.char_code;
    assign o_glyph.glyph_x      = r_out.glyph_x;
    assign o_glyph.glyph_y      = r_out.glyph_y;
    assign o_glyph.glyph_width  = r_out.glyph_width;
    assign o_glyph.glyph_height = r_out.glyph_height;
    assign o_glyph.last         = r_out.last;

endmodule

FILE: design/glyph_extent_scanner_core.sv
// Throughput: one pixel request per cycle unless stalled; one glyph record per cycle while the receiver is ready.
// The first record of a band passes through the band queue and the output register
// once the band's last pixel is accepted; the 16 records follow while the receiver is ready.
// A two-band queue sits between pixel scan and record output; pixel input
// stalls only on a band-ending pixel while both queue slots are occupied.
// Reset (synchronous, active low) clears counters, flags, queue and output
// valid, and sets background 0 and cell size 16 by 16.
module glyph_extent_scanner_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gesc_cfg_if.sink     i_cfg,
    gesc_pix_if.sink     i_pix,
    gesc_glyph_if.source o_glyph
);
    import gesc_pkg::*;

    logic [DATA_W-1:0] r_bg;
    logic [SIZE_W-1:0] r_cw, r_ch;
    t_sizes            sizes;

    logic  push, full, band_valid, pop;
    t_band push_band, head_band;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg <= BG_RESET;
            r_cw <= CW_RESET;
            r_ch <= CH_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BACKGROUND:  r_bg <= i_cfg.data;
                REG_CELL_WIDTH:  r_cw <= i_cfg.data[SIZE_W-1:0];
                REG_CELL_HEIGHT: r_ch <= i_cfg.data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign sizes.w = eff_size(r_cw);
    assign sizes.h = eff_size(r_ch);

    gesc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_size  (sizes),
        .i_bg    (r_bg[PIXEL_BITS-1:0]),
        .i_pix   (i_pix),
        .o_push  (push),
        .o_band  (push_band),
        .i_full  (full)
    );

    gesc_band_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_band),
        .o_full  (full),
        .o_valid (band_valid),
        .o_data  (head_band),
        .i_pop   (pop)
    );

    gesc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_size  (sizes),
        .i_valid (band_valid),
        .i_band  (head_band),
        .o_pop   (pop),
        .o_glyph (o_glyph)
    );

endmodule

FILE: design/gesc_checker.sv
module gesc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [gesc_pkg::CODE_W-1:0]  i_char_code,
    input logic [gesc_pkg::SIZE_W-1:0]  i_glyph_width,
    input logic [gesc_pkg::SIZE_W-1:0]  i_glyph_height,
    input logic                         i_last
);
    import gesc_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_char_code))
        else $error("stalled record dropped or changed");

    a_code_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=>
            !i_out_valid || (i_char_code == CODE_W'($past(i_char_code) + CODE_W'(1))))
        else $error("records of a band out of order");

    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_glyph_width != '0) && (i_glyph_height != '0))
        else $error("zero glyph size");

endmodule

bind glyph_extent_scanner_core gesc_checker u_gesc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_glyph.valid),
    .i_out_ready    (o_glyph.ready),
    .i_char_code    (o_glyph.char_code),
    .i_glyph_width  (o_glyph.glyph_width),
    .i_glyph_height (o_glyph.glyph_height),
    .i_last         (o_glyph.last)
);

FILE: tb/sv/glyph_check_pkg.sv
`timescale 1ns / 1ps
package glyph_check_pkg;
    import gesc_pkg::*;

    class glyph_scoreboard;
        logic [DATA_W-1:0] bg_color;
        logic [SIZE_W-1:0] width_reg;
        logic [SIZE_W-1:0] height_reg;
        int unsigned       col_in_cell;
        int unsigned       cell_col;
        int unsigned       row_in_cell;
        int unsigned       cell_row;
        bit                seen_fg[GRID_SIZE];
        int unsigned       left_col[GRID_SIZE];
        int unsigned       right_col[GRID_SIZE];
        t_glyph            glyph_queue[$];
        int                errors;
        int                bands;

        function new();
            bg_color    = BG_RESET;
            width_reg   = CW_RESET;
            height_reg  = CH_RESET;
            col_in_cell = 0;
            cell_col    = 0;
            row_in_cell = 0;
            cell_row    = 0;
            errors      = 0;
            bands       = 0;
            clear_band();
        endfunction

        function void clear_band();
            for (int c = 0; c < GRID_SIZE; c++) begin
                seen_fg[c]   = 1'b0;
                left_col[c]  = 0;
                right_col[c] = 0;
            end
        endfunction

        // zero acts as one, oversize clamps to the largest cell
        function int unsigned cell_extent(logic [SIZE_W-1:0] v);
            if (v == '0) begin
                return 1;
            end
            if (int'(v) > MAX_CELL_SIZE) begin
                return MAX_CELL_SIZE;
            end
            return int'(v);
        endfunction

        function void write_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_BACKGROUND:  bg_color   = data;
                REG_CELL_WIDTH:  width_reg  = data[SIZE_W-1:0];
                REG_CELL_HEIGHT: height_reg = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px);
            int unsigned w;
            int unsigned h;
            int unsigned x;
            int unsigned gw;
            t_glyph      g;
            w = cell_extent(width_reg);
            h = cell_extent(height_reg);
            if (px != bg_color && col_in_cell < w) begin
                if (!seen_fg[cell_col]) begin
                    seen_fg[cell_col]   = 1'b1;
                    left_col[cell_col]  = col_in_cell;
                    right_col[cell_col] = col_in_cell;
                end else begin
                    if (col_in_cell < left_col[cell_col]) begin
                        left_col[cell_col] = col_in_cell;
                    end
                    if (col_in_cell > right_col[cell_col]) begin
                        right_col[cell_col] = col_in_cell;
                    end
                end
            end
            col_in_cell++;
            if (col_in_cell >= w) begin
                col_in_cell = 0;
                cell_col++;
                if (cell_col >= GRID_SIZE) begin
                    cell_col = 0;
                    row_in_cell++;
                    if (row_in_cell >= h) begin
                        row_in_cell = 0;
                        for (int unsigned c = 0; c < GRID_SIZE; c++) begin
                            x  = c * w;
                            gw = w;
                            if (seen_fg[c]) begin
                                x += left_col[c];
                                gw = right_col[c] - left_col[c] + 1;
                            end
                            g.char_code    = CODE_W'(cell_row * GRID_SIZE + c);
                            g.glyph_x      = COORD_W'(x);
                            g.glyph_y      = COORD_W'(cell_row * h);
                            g.glyph_width  = SIZE_W'(gw);
                            g.glyph_height = SIZE_W'(h);
                            g.last         = (c == GRID_SIZE - 1);
                            glyph_queue.push_back(g);
                        end
                        clear_band();
                        cell_row = (cell_row + 1) % GRID_SIZE;
                        bands++;
                    end
                end
            end
        endfunction

        function int pending();
            return glyph_queue.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("ERROR %0t: %s", $realtime, msg);
            end
        endtask

        task check_glyph(t_glyph got);
            t_glyph want;
            if (glyph_queue.size() == 0) begin
                report($sformatf("glyph record with none expected, code %0d", got.char_code));
                return;
            end
            want = glyph_queue.pop_front();
            if (got.char_code !== want.char_code) begin
                report($sformatf("char_code: got %0d, expected %0d",
                                 got.char_code, want.char_code));
            end
            if (got.glyph_x !== want.glyph_x) begin
                report($sformatf("code %0d glyph_x: got %0d, expected %0d",
                                 want.char_code, got.glyph_x, want.glyph_x));
            end
            if (got.glyph_y !== want.glyph_y) begin
                report($sformatf("code %0d glyph_y: got %0d, expected %0d",
                                 want.char_code, got.glyph_y, want.glyph_y));
            end
            if (got.glyph_width !== want.glyph_width) begin
                report($sformatf("code %0d glyph_width: got %0d, expected %0d",
                                 want.char_code, got.glyph_width, want.glyph_width));
            end
            if (got.glyph_height !== want.glyph_height) begin
                report($sformatf("code %0d glyph_height: got %0d, expected %0d",
                                 want.char_code, got.glyph_height, want.glyph_height));
            end
            if (got.last !== want.last) begin
                report($sformatf("code %0d last: got %0b, expected %0b",
                                 want.char_code, got.last, want.last));
            end
        endtask
    endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import gesc_pkg::*;
    import glyph_check_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_PIXELS = 150;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gesc_cfg_if   cfg_if ();
    gesc_pix_if   pix_if ();
    gesc_glyph_if glyph_if ();

    glyph_extent_scanner_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_if),
        .o_glyph (glyph_if)
    );

    glyph_scoreboard sheet_sb;
    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int hold_requests = 0;
    int stall_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // glyph receiver; a long hold-off starts when hold_requests moves
    initial begin
        int seen_holds;
        int hold_left;
        seen_holds = 0;
        hold_left  = 0;
        glyph_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != seen_holds) begin
                seen_holds = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                glyph_if.ready <= 1'b0;
            end else begin
                glyph_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : glyph_monitor
        t_glyph got;
        if (i_rst_n && glyph_if.valid && glyph_if.ready) begin
            got.char_code    = glyph_if.char_code;
            got.glyph_x      = glyph_if.glyph_x;
            got.glyph_y      = glyph_if.glyph_y;
            got.glyph_width  = glyph_if.glyph_width;
            got.glyph_height = glyph_if.glyph_height;
            got.last         = glyph_if.last;
            sheet_sb.check_glyph(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (cfg_if.valid && cfg_if.ready)
                || (glyph_if.valid && glyph_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= value;
        @(posedge i_clk);
        while (!pix_if.ready) begin
            @(posedge i_clk);
        end
        sheet_sb.note_pixel(value);
    endtask

    // stop pixel requests, let all records drain, then let the pipe idle for the given tail
    task automatic wait_idle(input int tail);
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sheet_sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (tail) @(posedge i_clk);
    endtask

    // writes every index, the unused one included; size upper bits carry junk
    task automatic set_sheet_format(input logic [DATA_W-1:0] bg,
                                    input logic [SIZE_W-1:0] w,
                                    input logic [SIZE_W-1:0] h);
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] val;
        wait_idle(4);
        for (int i = 0; i < (1 << IDX_W); i++) begin
            idx = IDX_W'(i);
            val = $urandom();
            case (idx)
                REG_BACKGROUND:  val = bg;
                REG_CELL_WIDTH:  val[SIZE_W-1:0] = w;
                REG_CELL_HEIGHT: val[SIZE_W-1:0] = h;
                default: ;
            endcase
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx;
            cfg_if.data  <= val;
            @(posedge i_clk);
            while (!cfg_if.ready) begin
                @(posedge i_clk);
            end
            sheet_sb.write_register(idx, val);
        end
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] sheet_pixel(input logic [DATA_W-1:0] bg,
                                                     input int fg_pct);
        logic [PIX_W-1:0] px;
        px = bg;
        if ($urandom_range(99) < fg_pct) begin
            case ($urandom_range(2))
                0: px = $urandom();
                1: px = bg ^ (PIX_W'(1) << $urandom_range(PIX_W - 1));
                default: px = ~bg;
            endcase
        end
        return px;
    endfunction

    initial begin
        logic [PIX_W-1:0]  edge_values[4];
        logic [PIX_W-1:0]  fg;
        logic [DATA_W-1:0] bg;
        int                fg_pct;
        int                random_pixels;
        int                band_start;
        int                phase_len;

        edge_values = '{32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFE};
        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        sheet_sb     = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 31;
        snk_idle_pct = 65;

        // two-pixel cells: empty, left only, right only, both
        set_sheet_format(32'hFFFF_FFFF, 7'd2, 7'd0);
        for (int c = 0; c < GRID_SIZE; c++) begin
            fg = edge_values[c / 4];
            send_pixel(c[0] ? fg : 32'hFFFF_FFFF);
            send_pixel(c[1] ? fg : 32'hFFFF_FFFF);
        end

        // narrow cells up to the last column, then an oversize width ends the band
        set_sheet_format($urandom(), 7'd1, 7'd0);
        repeat (GRID_SIZE - 1) send_pixel(sheet_pixel(sheet_sb.bg_color, 30));
        set_sheet_format(sheet_sb.bg_color, 7'd127, 7'd0);
        repeat (MAX_CELL_SIZE) send_pixel(sheet_pixel(sheet_sb.bg_color, 10));

        // back-pressure: hold the receiver while requests keep coming
        set_sheet_format(32'h0, 7'd1, 7'd1);
        src_idle_pct = 0;
        hold_requests++;
        repeat (7 * GRID_SIZE) send_pixel(sheet_pixel(sheet_sb.bg_color, 50));

        random_pixels = 0;
        band_start    = sheet_sb.bands;
        while (random_pixels < RANDOM_PIXELS || sheet_sb.bands - band_start < 4) begin
            if (random_pixels < RANDOM_PIXELS / 3) begin
                src_idle_pct = 31;
                snk_idle_pct = 65;
            end else if (random_pixels < 2 * RANDOM_PIXELS / 3) begin
                src_idle_pct = 65;
                snk_idle_pct = 31;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            case ($urandom_range(3))
                0: bg = 32'h0;
                1: bg = 32'hFFFF_FFFF;
                default: bg = $urandom();
            endcase
            // phases can end mid-band, so size changes can land mid-scan
            set_sheet_format(bg, SIZE_W'($urandom_range(3)), SIZE_W'($urandom_range(2)));
            fg_pct    = $urandom_range(10, 60);
            phase_len = $urandom_range(20, 60);
            repeat (phase_len) send_pixel(sheet_pixel(sheet_sb.bg_color, fg_pct));
            random_pixels += phase_len;
        end

        wait_idle(20);
        if (sheet_sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
